// ===== hdl/agc_pkg.sv =====
// Package of the automatic gate controller: payload structs, state and
// configuration types, event and phase codes, reset constants and div3_u6.
// Used by every module of the controller; depends on nothing.
package agc_pkg;

    // Widths of the stored quantities.
    localparam int unsigned SecW   = 6;
    localparam int unsigned TickW  = 6;
    localparam int unsigned CountW = 12;

    // Reset values of the configuration registers and of the state.
    localparam logic [SecW-1:0]   HOLD_MIN_RESET  = 6'd10;
    localparam logic [SecW-1:0]   HOLD_MAX_RESET  = 6'd30;
    localparam logic [TickW-1:0]  MOVE_RESET      = 6'd12;
    localparam logic [TickW-1:0]  TPS_RESET       = 6'd20;
    localparam logic [SecW-1:0]   HOLD_TIME_RESET = 6'd10;
    localparam logic [2:0]        BARS_CLOSED     = 3'd4;
    localparam logic [CountW-1:0] OPEN_COUNT_MAX  = 12'd4095;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SETTINGS = 3'd1,
        OP_OPEN     = 3'd2,
        OP_MODE     = 3'd3,
        OP_TOGGLE   = 3'd4,
        OP_SAMPLE   = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        PH_CLOSED  = 2'd0,
        PH_OPENING = 2'd1,
        PH_OPEN    = 2'd2,
        PH_CLOSING = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        DISP_DASHES = 2'd0,
        DISP_AUTO   = 2'd1,
        DISP_HAND   = 2'd2,
        DISP_HOLD   = 2'd3
    } t_disp;

    typedef enum logic [1:0] {
        CFG_HOLD_MIN = 2'd0,
        CFG_HOLD_MAX = 2'd1,
        CFG_MOVE     = 2'd2,
        CFG_TPS      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      gate_state;
        logic            auto_mode;
        logic            in_settings;
        logic            editing_hold;
        logic [SecW-1:0] hold_seconds;
        logic [2:0]      bar_count;
        logic [1:0]      display_select;
        logic            red_led;
        logic            yellow_led;
        logic            green_led;
    } t_out_item;

    typedef struct packed {
        logic [SecW-1:0]  hold_min_s;
        logic [SecW-1:0]  hold_max_s;
        logic [TickW-1:0] move_ticks;
        logic [TickW-1:0] ticks_per_second;
    } t_cfg;

    typedef struct packed {
        t_phase            gate_phase;
        logic              mode_auto;
        logic              settings_on;
        logic              hold_edit_on;
        logic [SecW-1:0]   hold_time;
        logic [TickW-1:0]  move_count;
        logic [CountW-1:0] open_count;
        logic [2:0]        bars;
        logic              lamp;
    } t_state;

    // Division of a 6-bit value by three: multiply by 43/128, exact below 64.
    function automatic logic [5:0] div3_u6(input logic [5:0] x);
        logic [11:0] p;
        p = {6'd0, x} * 12'd43;
        return {1'b0, p[11:7]};
    endfunction

endpackage

// ===== hdl/agc_step.sv =====
// Next-state and result logic of the automatic gate controller for one event.
// Purely combinational; depends on agc_pkg.
module agc_step (
    input  agc_pkg::t_state    i_state,
    input  agc_pkg::t_cfg      i_cfg,
    input  agc_pkg::t_in_item  i_item,
    output agc_pkg::t_state    o_state,
    output agc_pkg::t_out_item o_result
);
    import agc_pkg::*;

    logic [CountW-1:0] thr;
    logic [CountW-1:0] oc_inc;
    logic [5:0]        span;
    logic [13:0]       prod;
    logic [15:0]       quo_sum;
    logic [5:0]        quo;
    logic [2:0]        step;
    t_state            nx;
    t_disp             disp;

    // The hold threshold in ticks and the scaled sample are both small products.
    assign thr  = {6'd0, i_state.hold_time} * {6'd0, i_cfg.ticks_per_second};
    assign span = (i_cfg.hold_max_s >= i_cfg.hold_min_s) ?
                  (i_cfg.hold_max_s - i_cfg.hold_min_s) : 6'd0;
    assign prod = {6'd0, i_item.adc_sample} * {8'd0, span};
    // x / 255 equals (x + (x >> 8) + 1) >> 8 for any x below 65535.
    assign quo_sum = {2'd0, prod} + {10'd0, prod[13:8]} + 16'd1;
    assign quo     = quo_sum[13:8];
    assign oc_inc  = (i_state.open_count < OPEN_COUNT_MAX) ?
                     (i_state.open_count + 12'd1) : i_state.open_count;

    always_comb begin
        nx   = i_state;
        step = 3'd4;
        unique case (i_item.opcode)
            OP_TICK: begin
                unique case (i_state.gate_phase)
                    PH_CLOSED:  nx.lamp = 1'b0;
                    PH_OPEN:    nx.lamp = 1'b1;
                    default:    nx.lamp = ~i_state.lamp;
                endcase
                if (i_state.gate_phase == PH_OPEN) begin
                    nx.open_count = oc_inc;
                    if (oc_inc >= thr && i_state.mode_auto) begin
                        nx.open_count = '0;
                        nx.gate_phase = PH_CLOSING;
                    end
                end
                // A gate that just began closing also advances on this tick.
                if (nx.gate_phase == PH_OPENING || nx.gate_phase == PH_CLOSING) begin
                    nx.move_count = i_state.move_count + 6'd1;
                    if (nx.move_count >= i_cfg.move_ticks) begin
                        nx.gate_phase = (nx.gate_phase == PH_OPENING) ? PH_OPEN : PH_CLOSED;
                        nx.move_count = '0;
                    end else begin
                        priority if (nx.move_count <= {2'd0, i_cfg.move_ticks[5:2]}) begin
                            step = 3'd1;
                        end else if (nx.move_count <= div3_u6(i_cfg.move_ticks)) begin
                            step = 3'd2;
                        end else if (nx.move_count <= {1'b0, i_cfg.move_ticks[5:1]}) begin
                            step = 3'd3;
                        end else begin
                            step = 3'd4;
                        end
                        nx.bars = (nx.gate_phase == PH_OPENING) ? (3'd4 - step) : step;
                    end
                end
            end
            OP_SETTINGS: begin
                nx.settings_on = ~i_state.settings_on;
                if (i_state.settings_on) begin
                    nx.hold_edit_on = 1'b0;
                end
            end
            OP_OPEN: begin
                if (i_state.settings_on) begin
                    nx.hold_edit_on = 1'b1;
                end else if (i_state.gate_phase == PH_CLOSED) begin
                    nx.gate_phase = PH_OPENING;
                end
            end
            OP_MODE: begin
                if (i_state.settings_on) begin
                    nx.hold_edit_on = 1'b0;
                    nx.mode_auto    = ~i_state.mode_auto;
                end
            end
            OP_TOGGLE: begin
                if (!i_state.mode_auto) begin
                    if (i_state.gate_phase == PH_CLOSED) begin
                        nx.gate_phase = PH_OPENING;
                    end else if (i_state.gate_phase == PH_OPEN) begin
                        nx.gate_phase = PH_CLOSING;
                    end
                end
            end
            OP_SAMPLE: begin
                if (i_state.settings_on && i_state.hold_edit_on) begin
                    nx.hold_time = quo + i_cfg.hold_min_s;
                end
            end
            default: begin
                nx = i_state;
            end
        endcase

        priority if (!nx.settings_on) begin
            disp = DISP_DASHES;
        end else if (nx.hold_edit_on) begin
            disp = DISP_HOLD;
        end else begin
            disp = nx.mode_auto ? DISP_AUTO : DISP_HAND;
        end
    end

    assign o_state = nx;

    assign o_result.gate_state     = nx.gate_phase;
    assign o_result.auto_mode      = nx.mode_auto;
    assign o_result.in_settings    = nx.settings_on;
    assign o_result.editing_hold   = nx.hold_edit_on;
    assign o_result.hold_seconds   = nx.hold_time;
    assign o_result.bar_count      = nx.bars;
    assign o_result.display_select = disp;
    assign o_result.red_led        = nx.settings_on;
    assign o_result.yellow_led     = ~nx.mode_auto;
    assign o_result.green_led      = nx.lamp;

endmodule

// ===== hdl/automatic_gate_controller_unit.sv =====
// Top level of the automatic gate controller: input register, controller
// state, configuration registers and output register; depends on agc_pkg
// and agc_step.
//
// Each transfer on the input channel is one event (a timer tick, one of four
// button presses, or a potentiometer sample) and yields exactly one result
// transfer, carrying the gate phase, mode flags, hold time, dash animation
// and LED levels as they stand after the event. The block takes one event
// per clock cycle while the receiver does not stall: an event waits in the
// input register while the next state and its result are computed, then the
// controller state and the output register update together, so a result is
// offered from the output register once its event leaves the input register.
// The whole state update is a single short combinational step; the main
// arithmetic is a 6x6 multiply for the hold threshold and an 8x6 multiply
// followed by an exact add-shift division by 255 for the sample scaling. The
// output register holds a result while the receiver stalls, and a new event
// is still taken into the empty input register meanwhile. Configuration
// registers are written through the plain write port and must only be
// written while no event is in flight.
module automatic_gate_controller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  agc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output agc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data
);
    import agc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_cfg      r_cfg;
    t_state    n_state;
    t_out_item n_out;
    logic      advance;
    logic      in_xfer;

    // The held event moves on whenever the output register is free or is
    // being emptied in this same cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    agc_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.gate_phase   <= PH_CLOSED;
            r_state.mode_auto    <= 1'b1;
            r_state.settings_on  <= 1'b0;
            r_state.hold_edit_on <= 1'b0;
            r_state.hold_time    <= HOLD_TIME_RESET;
            r_state.move_count   <= '0;
            r_state.open_count   <= '0;
            r_state.bars         <= BARS_CLOSED;
            r_state.lamp         <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_min_s       <= HOLD_MIN_RESET;
            r_cfg.hold_max_s       <= HOLD_MAX_RESET;
            r_cfg.move_ticks       <= MOVE_RESET;
            r_cfg.ticks_per_second <= TPS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HOLD_MIN: r_cfg.hold_min_s       <= i_cfg_data;
                CFG_HOLD_MAX: r_cfg.hold_max_s       <= i_cfg_data;
                CFG_MOVE:     r_cfg.move_ticks       <= i_cfg_data;
                CFG_TPS:      r_cfg.ticks_per_second <= i_cfg_data;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/agc_checker.sv =====
// Port-level checker of the automatic gate controller and its bind to the
// top level; depends on agc_pkg.
module agc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input agc_pkg::t_out_item o_out_data
);
    import agc_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or was dropped");

    // Hold editing exists only inside the settings mode.
    a_edit_in_settings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.editing_hold || o_out_data.in_settings))
        else $error("hold editing outside settings mode");

    // The display shows gate dashes exactly when settings mode is off.
    a_disp_dashes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.display_select == DISP_DASHES)
                         == !o_out_data.in_settings))
        else $error("display select disagrees with settings mode");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind automatic_gate_controller_unit agc_checker u_agc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== sim/automatic_gate_controller_unit_tb.sv =====
// Testbench of the automatic gate controller: directed and random event streams
// with random idling on both channels, checked against a predictor of the gate.
// Depends on agc_pkg and automatic_gate_controller_unit.
module automatic_gate_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import agc_pkg::*;

    // Upper bound on the run in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Longest idle gap drawn per transfer on either channel.
    localparam int unsigned MAX_GAP = 19;
    // Length of the receiver hold-off that fills the block up.
    localparam int unsigned LONG_HOLD = 150;
    // Cycles left after the last result before a register write or the end.
    localparam int unsigned SETTLE = 6;
    localparam int unsigned MAX_REPORTS = 10;
    // The two opcodes that the block decodes as no operation.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [5:0] i_cfg_data;

    // Predicted controller state and the configuration it runs under.
    t_state gate_q;
    t_cfg   cfg_q;
    // Reports the block still owes, oldest first.
    t_out_item gate_reports_due[$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned events_sent = 0;
    // When idle_on is low both channels run back to back.
    bit idle_on = 1'b0;
    // A request to the receiver to hold off once, as long as LONG_HOLD sets.
    bit long_hold = 1'b0;

    automatic_gate_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One timer tick. The lamp follows the phase as it was before the tick.
    // An open gate counts ticks and, in automatic mode, starts closing once
    // the count reaches the hold time in ticks; the same tick then already
    // counts as the first step of the closing movement.
    task automatic advance_tick();
        int close_at;
        int moved;
        int span_ticks;
        int step;
        close_at = int'(gate_q.hold_time) * int'(cfg_q.ticks_per_second);
        case (gate_q.gate_phase)
            PH_CLOSED: gate_q.lamp = 1'b0;
            PH_OPEN:   gate_q.lamp = 1'b1;
            default:   gate_q.lamp = ~gate_q.lamp;
        endcase
        if (gate_q.gate_phase == PH_OPEN) begin
            if (gate_q.open_count != OPEN_COUNT_MAX)
                gate_q.open_count = gate_q.open_count + 1'b1;
            if (int'(gate_q.open_count) >= close_at && gate_q.mode_auto) begin
                gate_q.open_count = '0;
                gate_q.gate_phase = PH_CLOSING;
            end
        end
        if (gate_q.gate_phase == PH_OPENING || gate_q.gate_phase == PH_CLOSING) begin
            // The movement counter is six bits wide and wraps.
            gate_q.move_count = gate_q.move_count + 1'b1;
            moved = int'(gate_q.move_count);
            span_ticks = int'(cfg_q.move_ticks);
            if (moved >= span_ticks) begin
                if (gate_q.gate_phase == PH_OPENING)
                    gate_q.gate_phase = PH_OPEN;
                else
                    gate_q.gate_phase = PH_CLOSED;
                gate_q.move_count = '0;
            end else begin
                if (moved <= span_ticks / 4)
                    step = 1;
                else if (moved <= span_ticks / 3)
                    step = 2;
                else if (moved <= span_ticks / 2)
                    step = 3;
                else
                    step = 4;
                if (gate_q.gate_phase == PH_OPENING)
                    gate_q.bars = 3'(4 - step);
                else
                    gate_q.bars = 3'(step);
            end
        end
    endtask

    // Applies one event to the predicted state and forms the report the
    // block must give for it.
    task automatic gate_after_event(input t_in_item ev, output t_out_item rep);
        int span;
        t_disp shown;
        case (ev.opcode)
            OP_TICK: advance_tick();
            OP_SETTINGS: begin
                gate_q.settings_on = ~gate_q.settings_on;
                if (!gate_q.settings_on)
                    gate_q.hold_edit_on = 1'b0;
            end
            OP_OPEN: begin
                if (gate_q.settings_on)
                    gate_q.hold_edit_on = 1'b1;
                else if (gate_q.gate_phase == PH_CLOSED)
                    gate_q.gate_phase = PH_OPENING;
            end
            OP_MODE: begin
                if (gate_q.settings_on) begin
                    gate_q.hold_edit_on = 1'b0;
                    gate_q.mode_auto = ~gate_q.mode_auto;
                end
            end
            OP_TOGGLE: begin
                if (!gate_q.mode_auto) begin
                    if (gate_q.gate_phase == PH_CLOSED)
                        gate_q.gate_phase = PH_OPENING;
                    else if (gate_q.gate_phase == PH_OPEN)
                        gate_q.gate_phase = PH_CLOSING;
                end
            end
            OP_SAMPLE: begin
                // A maximum below the minimum gives an empty span.
                if (gate_q.settings_on && gate_q.hold_edit_on) begin
                    if (cfg_q.hold_max_s >= cfg_q.hold_min_s)
                        span = int'(cfg_q.hold_max_s) - int'(cfg_q.hold_min_s);
                    else
                        span = 0;
                    gate_q.hold_time = SecW'((int'(ev.adc_sample) * span) / 255
                                             + int'(cfg_q.hold_min_s));
                end
            end
            default: ;
        endcase

        if (!gate_q.settings_on)
            shown = DISP_DASHES;
        else if (gate_q.hold_edit_on)
            shown = DISP_HOLD;
        else if (gate_q.mode_auto)
            shown = DISP_AUTO;
        else
            shown = DISP_HAND;

        rep.gate_state     = gate_q.gate_phase;
        rep.auto_mode      = gate_q.mode_auto;
        rep.in_settings    = gate_q.settings_on;
        rep.editing_hold   = gate_q.hold_edit_on;
        rep.hold_seconds   = gate_q.hold_time;
        rep.bar_count      = gate_q.bars;
        rep.display_select = shown;
        rep.red_led        = gate_q.settings_on;
        rep.yellow_led     = ~gate_q.mode_auto;
        rep.green_led      = gate_q.lamp;
    endtask

    function automatic string show_report(input t_out_item r);
        return $sformatf("phase=%0d auto=%0b set=%0b edit=%0b hold=%0d bars=%0d disp=%0d rgy=%b%b%b",
                         r.gate_state, r.auto_mode, r.in_settings, r.editing_hold,
                         r.hold_seconds, r.bar_count, r.display_select,
                         r.red_led, r.yellow_led, r.green_led);
    endfunction

    // A random potentiometer sample.
    function automatic logic [7:0] rand_sample();
        return 8'($urandom_range(255, 0));
    endfunction

    // ------------------------------------------------------------------
    // Channels
    // ------------------------------------------------------------------

    // Offers one event and waits for its transfer. Every call starts in the
    // time step of a rising edge; the valid stays high on return so that a
    // following event can go back to back. Anything else that follows must
    // lower it first.
    task automatic send_event(input logic [2:0] op, input logic [7:0] sample);
        t_in_item  ev;
        t_out_item rep;
        int unsigned gap;
        ev.opcode = op;
        ev.adc_sample = sample;
        gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        // Stall is read right after the edge, so it is the value the block
        // presented at that edge.
        do @(posedge i_clk); while (o_in_stall);
        gate_after_event(ev, rep);
        gate_reports_due.push_back(rep);
        events_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_event(OP_TICK, rand_sample());
    endtask

    // Lowers the input valid and waits until every report has arrived and
    // the block has had time to settle.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (gate_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [5:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HOLD_MIN: cfg_q.hold_min_s       = val;
            CFG_HOLD_MAX: cfg_q.hold_max_s       = val;
            CFG_MOVE:     cfg_q.move_ticks       = val;
            CFG_TPS:      cfg_q.ticks_per_second = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] hold_min, input logic [5:0] hold_max,
                              input logic [5:0] move, input logic [5:0] tps);
        settle_block();
        write_reg(CFG_HOLD_MIN, hold_min);
        write_reg(CFG_HOLD_MAX, hold_max);
        write_reg(CFG_MOVE, move);
        write_reg(CFG_TPS, tps);
    endtask

    // Receiver: draws a stall length for each report, or holds off for a
    // long stretch when asked to, then takes the next report.
    initial begin : take_reports
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold) begin
                hold = LONG_HOLD;
                long_hold = 1'b0;
            end else begin
                hold = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Every report transfer is compared with the oldest one due.
    always @(posedge i_clk) begin : check_reports
        t_out_item due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gate_reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected report: %s", show_report(o_out_data));
            end else begin
                due = gate_reports_due.pop_front();
                if (o_out_data !== due) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("report mismatch at cycle %0d", cycles);
                        $display("  expected %s", show_report(due));
                        $display("  actual   %s", show_report(o_out_data));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Settings menu: both display texts, hold editing at the sample
    // extremes, and a mode change that also stops editing. The last sample
    // leaves a hold time of one second for the automatic cycle.
    task automatic test_settings_menu();
        set_config(6'd0, 6'd63, 6'd4, 6'd1);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_OPEN, 8'h00);
        send_event(OP_SAMPLE, 8'hFF);
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_SAMPLE, 8'h05);
        send_event(OP_MODE, 8'hFF);
        send_event(OP_MODE, 8'h00);
        send_event(OP_SETTINGS, 8'hFF);
    endtask

    // Automatic mode: open, run to the open phase, close by timeout. The
    // toggle button and a second open press do nothing here, and the two
    // spare opcodes change nothing at all.
    task automatic test_auto_cycle();
        send_event(OP_OPEN, 8'h00);
        send_event(OP_OPEN, 8'h00);
        send_ticks(4);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(5);
        send_event(OP_SPARE_A, 8'hFF);
        send_event(OP_SPARE_B, 8'hAA);
    endtask

    // Hand mode: the mode button outside the menu is ignored; the toggle
    // opens and closes, and an open gate stays open however long it waits.
    task automatic test_hand_mode();
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_MODE, 8'h00);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_MODE, 8'h00);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(7);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(4);
    endtask

    // A maximum below the minimum: every sample gives the minimum.
    task automatic test_inverted_span();
        set_config(6'd40, 6'd20, 6'd63, 6'd63);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_OPEN, 8'h00);
        send_event(OP_SAMPLE, 8'hC8);
        send_event(OP_SETTINGS, 8'h00);
    endtask

    // The movement length is cut while the gate is still opening; the next
    // tick must end the movement.
    task automatic test_shortened_move();
        send_event(OP_OPEN, 8'h00);
        send_ticks(6);
        settle_block();
        write_reg(CFG_MOVE, 6'd4);
        send_ticks(1);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(4);
    endtask

    // The open counter grows past the one-second hold time in hand mode and
    // survives closing by hand and the change back to automatic mode, so
    // the next open gate closes on its first tick.
    task automatic test_counter_kept();
        set_config(6'd1, 6'd1, 6'd4, 6'd20);
        idle_on = 1'b0;
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_OPEN, 8'h00);
        send_event(OP_SAMPLE, 8'h00);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(4 + 30);
        send_event(OP_TOGGLE, 8'h00);
        send_ticks(4);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_MODE, 8'h00);
        send_event(OP_SETTINGS, 8'h00);
        send_event(OP_OPEN, 8'h00);
        send_ticks(4 + 1 + 4);
    endtask

    // The receiver holds off while events keep coming back to back, so the
    // block fills up and has to stall its input.
    task automatic test_backpressure();
        settle_block();
        idle_on = 1'b0;
        long_hold = 1'b1;
        send_ticks(30);
    endtask

    // Random events, mostly ticks and buttons, with complete visits to the
    // settings menu mixed in so that editing and mode changes happen often.
    // The idling switches on and off in stretches.
    task automatic random_events(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            if ($urandom_range(39, 0) == 0)
                idle_on = ($urandom_range(2, 0) != 0);
            pick = $urandom_range(99, 0);
            if (pick < 6) begin
                send_event(OP_SETTINGS, rand_sample());
                if ($urandom_range(3, 0) != 0) begin
                    send_event(OP_OPEN, rand_sample());
                    repeat ($urandom_range(3, 1))
                        send_event(OP_SAMPLE, rand_sample());
                end
                if ($urandom_range(2, 0) == 0)
                    send_event(OP_MODE, rand_sample());
                send_event(OP_SETTINGS, rand_sample());
            end else if (pick < 50)
                send_event(OP_TICK, rand_sample());
            else if (pick < 58)
                send_event(OP_OPEN, rand_sample());
            else if (pick < 63)
                send_event(OP_MODE, rand_sample());
            else if (pick < 75)
                send_event(OP_TOGGLE, rand_sample());
            else if (pick < 80)
                send_event(OP_SETTINGS, rand_sample());
            else if (pick < 98)
                send_event(OP_SAMPLE, rand_sample());
            else
                send_event($urandom_range(1, 0) ? OP_SPARE_A : OP_SPARE_B,
                           rand_sample());
        end
    endtask

    // Four random phases: fast automatic closing, an empty hold span with
    // a zero maximum, every register at its top value, and a random setting.
    task automatic test_random_traffic();
        set_config(6'd0, 6'd5, 6'd4, 6'd1);
        random_events(300);
        set_config(6'd3, 6'd0, 6'd9, 6'd2);
        random_events(300);
        set_config(6'd63, 6'd63, 6'd63, 6'd63);
        random_events(300);
        set_config(6'($urandom_range(8, 0)), 6'($urandom_range(12, 0)),
                   6'($urandom_range(20, 4)), 6'($urandom_range(4, 1)));
        random_events(300);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;

        cfg_q.hold_min_s       = HOLD_MIN_RESET;
        cfg_q.hold_max_s       = HOLD_MAX_RESET;
        cfg_q.move_ticks       = MOVE_RESET;
        cfg_q.ticks_per_second = TPS_RESET;
        gate_q.gate_phase   = PH_CLOSED;
        gate_q.mode_auto    = 1'b1;
        gate_q.settings_on  = 1'b0;
        gate_q.hold_edit_on = 1'b0;
        gate_q.hold_time    = HOLD_TIME_RESET;
        gate_q.move_count   = '0;
        gate_q.open_count   = '0;
        gate_q.bars         = BARS_CLOSED;
        gate_q.lamp         = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first events run against the reset configuration.
        idle_on = 1'b1;
        send_event(OP_TICK, 8'h00);
        send_event(OP_SAMPLE, 8'hFF);

        test_settings_menu();
        test_auto_cycle();
        test_hand_mode();
        test_inverted_span();
        test_shortened_move();
        test_counter_kept();
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (mismatches == 0 && gate_reports_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
